FILE: hw/rtl/swmm_pkg.sv
package swmm_pkg;

    localparam int MAX_WINDOW   = 16;
    localparam int SAMPLE_WIDTH = 16;

    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W  = 5;
    localparam int WNUM_W = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_LENGTH = APB_ADDR_W'(0);
    localparam logic [CFG_W-1:0]      WINDOW_LENGTH_RST  = CFG_W'(3);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // control for the shared compare unit
    typedef struct packed {
        logic    init;
        logic    upd;
        t_sample load_val;
    } t_scan_ctl;

    // zero means one sample, anything above the store depth saturates
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return LEN_W'(1);
        end
        if (32'(v) > MAX_WINDOW) begin
            return LEN_W'(MAX_WINDOW);
        end
        return LEN_W'(v);
    endfunction

endpackage

FILE: hw/rtl/swmm_hist.sv
module swmm_hist (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [swmm_pkg::PTR_W-1:0]     i_wr_addr,
    input  swmm_pkg::t_sample              i_wr_data,
    input  logic                           i_rd_en,
    input  logic [swmm_pkg::PTR_W-1:0]     i_rd_addr,
    output swmm_pkg::t_sample              o_rd_data
);
    import swmm_pkg::*;

    t_sample r_mem [MAX_WINDOW];
    t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/swmm_scan.sv
module swmm_scan (
    input  logic                  i_clk,
    input  swmm_pkg::t_scan_ctl   i_ctl,
    input  swmm_pkg::t_sample     i_mem_val,
    output swmm_pkg::t_sample     o_lo,
    output swmm_pkg::t_sample     o_hi
);
    import swmm_pkg::*;

    t_sample r_lo;
    t_sample r_hi;
    t_sample n_lo;
    t_sample n_hi;

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_ctl.init) begin
            n_lo = i_ctl.load_val;
            n_hi = i_ctl.load_val;
        end else if (i_ctl.upd) begin
            if (i_mem_val < r_lo) begin
                n_lo = i_mem_val;
            end
            if (i_mem_val > r_hi) begin
                n_hi = i_mem_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

FILE: hw/rtl/sliding_window_min_max_range.sv
// Channel   Dir  Payload (lowest bits first)
// s_axis    in   tdata: sample_value[15:0]; tuser: series_start
// m_axis    out  tdata: window_number, window_min, window_max, variation (16 bits each)
// apb       in   window_length at byte address 0
//
// No window completed: one sample per cycle. With a result, for a window of L
// samples (zero reads as one, above 16 clamps to 16): store and load the
// compare unit, L - 1 history reads, drain the last read, load the output; no
// new sample is taken meanwhile. A one-sample window skips reads and drain.
// The output register lets the next sample in while a result waits; a stall
// on m_axis holds the block in its final step. Reset is synchronous.
module sliding_window_min_max_range (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [15:0]                           s_axis_tdata,  // sample_value
    input  logic [0:0]                            s_axis_tuser,  // series_start
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // window_number, window_min, window_max, variation
    output logic [63:0]                           m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [swmm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [swmm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [swmm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import swmm_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CFG_W-1:0]    r_wlen;
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    n_head;
    logic [LEN_W-1:0]    r_fill;
    logic [LEN_W-1:0]    n_fill;
    logic [WNUM_W-1:0]   r_wnum;
    logic [WNUM_W-1:0]   n_wnum;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [PTR_W-1:0]    n_rd_ptr;
    logic [PTR_W-1:0]    r_left;
    logic [PTR_W-1:0]    n_left;
    logic                r_pend;
    logic                n_pend;
    logic                r_out_vld;
    logic                n_out_vld;
    logic [63:0]         r_out_data;

    logic                in_xfer;
    logic                out_load;
    logic                rd_en;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    fill_base;
    logic [WNUM_W-1:0]   wnum_base;
    t_scan_ctl           scan_ctl;
    t_sample             mem_val;
    t_sample             lo;
    t_sample             hi;
    t_sample             span;

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(MAX_WINDOW - 1) : p - PTR_W'(1);
    endfunction

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_WINDOW_LENGTH) begin
            prdata = APB_DATA_W'(r_wlen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WINDOW_LENGTH_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_WINDOW_LENGTH) begin
            r_wlen <= pwdata[CFG_W-1:0];
        end
    end

    assign len       = eff_len(r_wlen);
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign fill_base = s_axis_tuser[0] ? '0 : r_fill;
    assign wnum_base = s_axis_tuser[0] ? '0 : r_wnum;
    assign span      = hi - lo;

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_fill        = r_fill;
        n_wnum        = r_wnum;
        n_rd_ptr      = r_rd_ptr;
        n_left        = r_left;
        n_pend        = 1'b0;
        n_out_vld     = r_out_vld;
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        scan_ctl      = '{init: 1'b0, upd: r_pend, load_val: t_sample'(s_axis_tdata)};

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_xfer) begin
                    n_head = (r_head == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_head + PTR_W'(1);
                    n_fill = (32'(fill_base) < MAX_WINDOW) ? fill_base + LEN_W'(1)
                                                           : fill_base;
                    n_wnum = wnum_base;
                    scan_ctl.init = 1'b1;
                    if (n_fill >= len) begin
                        n_wnum   = wnum_base + WNUM_W'(1);
                        n_rd_ptr = ptr_dec(r_head);
                        n_left   = PTR_W'(len - LEN_W'(1));
                        n_state  = (len == LEN_W'(1)) ? ST_EMIT : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_left != '0) begin
                    rd_en    = 1'b1;
                    n_pend   = 1'b1;
                    n_rd_ptr = ptr_dec(r_rd_ptr);
                    n_left   = r_left - PTR_W'(1);
                end else begin
                    // last read lands in the compare unit at this edge
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_vld || m_axis_tready) begin
                    out_load  = 1'b1;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_fill    <= '0;
            r_wnum    <= '0;
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_wnum    <= n_wnum;
            r_left    <= n_left;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        if (out_load) begin
            r_out_data <= {16'(span), 16'(hi), 16'(lo), r_wnum};
        end
    end

    swmm_hist u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer),
        .i_wr_addr (r_head),
        .i_wr_data (t_sample'(s_axis_tdata)),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (mem_val)
    );

    swmm_scan u_scan (
        .i_clk     (i_clk),
        .i_ctl     (scan_ctl),
        .i_mem_val (mem_val),
        .o_lo      (lo),
        .o_hi      (hi)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: hw/rtl/swmm_checker.sv
module swmm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:48] == 16'(m_axis_tdata[47:32] - m_axis_tdata[31:16]))
        else $error("variation is not max minus min");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[31:16]) <= $signed(m_axis_tdata[47:32]))
        else $error("window minimum above maximum");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule

bind sliding_window_min_max_range swmm_checker u_swmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
